// ===== rtl/core/pit_pkg.sv =====
package pit_pkg;

	localparam int MAX_PLANES = 64;
	localparam int MAX_POINTS = 256;
	localparam int ID_BITS    = 16;

	localparam int COORD_W  = 32;
	localparam int OUT_ID_W = 16;
	localparam int THR_W    = 31;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(6554);

	localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int CNT_W   = $clog2(MAX_PLANES + 1);
	localparam int ADDR_W  = $clog2(2 * MAX_PLANES);
	localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SUM_W   = COORD_W + $clog2(MAX_POINTS);
	localparam int STEP_W  = $clog2(SUM_W);
	localparam int DIST_W  = COORD_W + 1;

	localparam logic OP_POINT = 1'b0;
	localparam logic OP_EOF   = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [PCNT_W-1:0]         pcnt_t;
	typedef logic [ID_BITS-1:0]        id_t;

endpackage

// ===== rtl/core/pit_div.sv =====
module pit_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pit_pkg::sum_t   dividend,
	input  pit_pkg::pcnt_t  divisor,
	output logic            done,
	output pit_pkg::coord_t quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [pit_pkg::STEP_W-1:0]   cnt_q;
	logic                         neg_q;
	logic [pit_pkg::SUM_W-1:0]    mag_q;
	logic [pit_pkg::PCNT_W-1:0]   rem_q;
	pit_pkg::pcnt_t               div_q;

	logic [pit_pkg::PCNT_W:0]     rem_sh;
	logic [pit_pkg::PCNT_W:0]     rem_diff;
	logic                         ge;
	logic [pit_pkg::PCNT_W-1:0]   rem_nxt;
	logic [pit_pkg::COORD_W-1:0]  q_mag;

	// restoring division on the magnitude, one quotient bit per cycle
	always_comb begin
		rem_sh   = {rem_q, mag_q[pit_pkg::SUM_W-1]};
		ge       = (rem_sh >= {1'b0, div_q});
		rem_diff = rem_sh - {1'b0, div_q};
		rem_nxt  = ge ? rem_diff[pit_pkg::PCNT_W-1:0] : rem_sh[pit_pkg::PCNT_W-1:0];
		q_mag    = mag_q[pit_pkg::COORD_W-1:0];
	end

	assign quotient = neg_q ? pit_pkg::coord_t'(-q_mag) : pit_pkg::coord_t'(q_mag);
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				div_q  <= divisor;
				neg_q  <= dividend[pit_pkg::SUM_W-1];
				mag_q  <= dividend[pit_pkg::SUM_W-1] ? pit_pkg::SUM_W'(-dividend)
					: pit_pkg::SUM_W'(dividend);
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				mag_q <= {mag_q[pit_pkg::SUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pit_pkg::STEP_W'(pit_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/plane_id_tracker.sv =====
// channel  | handshake            | payload
// cfg      | cfg_we               | cfg_data (match_threshold)
// in       | in_valid / in_ready  | op, point_x, point_y, point_z, last_point
// out      | out_valid / out_ready| plane_id, centroid_x/y/z, reused, table_full
//
// a point that is not last and an end-of-frame word are each taken in idle.
// a last point runs x, y and z through the shared divider in turn; the search
// then reads, diffs and compares each previous-frame table entry, then emits.
// the result sits in an output register; new points are taken while it waits,
// but a finished plane holds in the emit step until that register is free.
// reset clears all counters, sums, bank select and the threshold to its default.
module plane_id_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pit_pkg::THR_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  pit_pkg::coord_t               point_x,
	input  pit_pkg::coord_t               point_y,
	input  pit_pkg::coord_t               point_z,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pit_pkg::OUT_ID_W-1:0]  plane_id,
	output pit_pkg::coord_t               centroid_x,
	output pit_pkg::coord_t               centroid_y,
	output pit_pkg::coord_t               centroid_z,
	output logic                          reused,
	output logic                          table_full
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RD,
		ST_DIFF,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	state_t                        state_q;
	axis_t                         axis_q;
	logic [pit_pkg::THR_W-1:0]     thr_q;
	logic                          bank_q;
	logic [pit_pkg::CNT_W-1:0]     prev_cnt_q;
	logic [pit_pkg::CNT_W-1:0]     cur_cnt_q;
	pit_pkg::sum_t                 sum_x_q;
	pit_pkg::sum_t                 sum_y_q;
	pit_pkg::sum_t                 sum_z_q;
	pit_pkg::pcnt_t                pcnt_q;
	pit_pkg::id_t                  next_id_q;
	pit_pkg::coord_t               cx_q;
	pit_pkg::coord_t               cy_q;
	pit_pkg::coord_t               cz_q;
	logic [pit_pkg::PLANE_W-1:0]   idx_q;
	logic [pit_pkg::DIST_W-1:0]    dist_q;
	logic [pit_pkg::DIST_W-1:0]    best_q;
	logic                          found_q;
	pit_pkg::id_t                  match_id_q;
	logic                          out_valid_q;
	logic [pit_pkg::OUT_ID_W-1:0]  plane_id_q;
	pit_pkg::coord_t               cent_x_q;
	pit_pkg::coord_t               cent_y_q;
	pit_pkg::coord_t               cent_z_q;
	logic                          reused_q;
	logic                          full_q;

	pit_pkg::coord_t               mem_z [2*pit_pkg::MAX_PLANES];
	pit_pkg::id_t                  mem_id [2*pit_pkg::MAX_PLANES];
	pit_pkg::coord_t               rd_z_q;
	pit_pkg::id_t                  rd_id_q;

	logic                          in_fire;
	logic                          emit_fire;
	logic                          tbl_full;
	logic                          tbl_we;
	pit_pkg::id_t                  emit_id;
	logic [pit_pkg::ADDR_W-1:0]    wr_addr;
	logic [pit_pkg::ADDR_W-1:0]    rd_addr;
	logic                          div_start;
	pit_pkg::sum_t                 div_dividend;
	logic                          div_done;
	pit_pkg::coord_t               div_quot;
	logic signed [pit_pkg::DIST_W-1:0] z_diff;
	logic [pit_pkg::DIST_W-1:0]    z_dist;
	logic [pit_pkg::DIST_W-1:0]    thr_ext;
	logic                          is_match;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign tbl_full  = (cur_cnt_q == pit_pkg::CNT_W'(pit_pkg::MAX_PLANES));
	assign tbl_we    = emit_fire && !tbl_full;
	assign emit_id   = found_q ? match_id_q : next_id_q;

	// bank b occupies entries b*MAX_PLANES and up
	assign wr_addr = bank_q
		? pit_pkg::ADDR_W'(pit_pkg::MAX_PLANES) + pit_pkg::ADDR_W'(cur_cnt_q)
		: pit_pkg::ADDR_W'(cur_cnt_q);
	assign rd_addr = bank_q
		? pit_pkg::ADDR_W'(idx_q)
		: pit_pkg::ADDR_W'(pit_pkg::MAX_PLANES) + pit_pkg::ADDR_W'(idx_q);

	assign div_start = (state_q == ST_DIV_GO);

	always_comb begin
		unique case (axis_q)
			AXIS_X:  div_dividend = sum_x_q;
			AXIS_Y:  div_dividend = sum_y_q;
			default: div_dividend = sum_z_q;
		endcase
	end

	pit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (pcnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		z_diff   = {rd_z_q[pit_pkg::COORD_W-1], rd_z_q} - {cz_q[pit_pkg::COORD_W-1], cz_q};
		z_dist   = z_diff[pit_pkg::DIST_W-1] ? pit_pkg::DIST_W'(-z_diff)
			: pit_pkg::DIST_W'(z_diff);
		thr_ext  = pit_pkg::DIST_W'(thr_q);
		is_match = (dist_q < thr_ext) && (!found_q || (dist_q < best_q));
	end

	// centroid table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			mem_z[wr_addr]  <= cz_q;
			mem_id[wr_addr] <= emit_id;
		end
		if (state_q == ST_RD) begin
			rd_z_q  <= mem_z[rd_addr];
			rd_id_q <= mem_id[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= AXIS_X;
			thr_q       <= pit_pkg::THR_RESET;
			bank_q      <= 1'b0;
			prev_cnt_q  <= '0;
			cur_cnt_q   <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			pcnt_q      <= '0;
			next_id_q   <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			idx_q       <= '0;
			dist_q      <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			match_id_q  <= '0;
			out_valid_q <= 1'b0;
			plane_id_q  <= '0;
			cent_x_q    <= '0;
			cent_y_q    <= '0;
			cent_z_q    <= '0;
			reused_q    <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (op == pit_pkg::OP_EOF) begin
							bank_q     <= ~bank_q;
							prev_cnt_q <= cur_cnt_q;
							cur_cnt_q  <= '0;
							sum_x_q    <= '0;
							sum_y_q    <= '0;
							sum_z_q    <= '0;
							pcnt_q     <= '0;
						end else begin
							// points past capacity are dropped
							if (pcnt_q < pit_pkg::PCNT_W'(pit_pkg::MAX_POINTS)) begin
								sum_x_q <= sum_x_q + pit_pkg::SUM_W'(point_x);
								sum_y_q <= sum_y_q + pit_pkg::SUM_W'(point_y);
								sum_z_q <= sum_z_q + pit_pkg::SUM_W'(point_z);
								pcnt_q  <= pcnt_q + 1'b1;
							end
							if (last_point) begin
								axis_q  <= AXIS_X;
								state_q <= ST_DIV_GO;
							end
						end
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						unique case (axis_q)
							AXIS_X: begin
								cx_q    <= div_quot;
								axis_q  <= AXIS_Y;
								state_q <= ST_DIV_GO;
							end
							AXIS_Y: begin
								cy_q    <= div_quot;
								axis_q  <= AXIS_Z;
								state_q <= ST_DIV_GO;
							end
							default: begin
								cz_q    <= div_quot;
								idx_q   <= '0;
								found_q <= 1'b0;
								state_q <= (prev_cnt_q == '0) ? ST_EMIT : ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					dist_q  <= z_dist;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// strict less-than keeps the first of equal distances
					if (is_match) begin
						found_q    <= 1'b1;
						best_q     <= dist_q;
						match_id_q <= rd_id_q;
					end
					idx_q <= idx_q + 1'b1;
					if (pit_pkg::CNT_W'(idx_q) + 1'b1 == prev_cnt_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						plane_id_q  <= pit_pkg::OUT_ID_W'(emit_id);
						cent_x_q    <= cx_q;
						cent_y_q    <= cy_q;
						cent_z_q    <= cz_q;
						reused_q    <= found_q;
						full_q      <= tbl_full;
						if (!found_q) begin
							next_id_q <= next_id_q + 1'b1;
						end
						if (!tbl_full) begin
							cur_cnt_q <= cur_cnt_q + 1'b1;
						end
						sum_x_q <= '0;
						sum_y_q <= '0;
						sum_z_q <= '0;
						pcnt_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign plane_id   = plane_id_q;
	assign centroid_x = cent_x_q;
	assign centroid_y = cent_y_q;
	assign centroid_z = cent_z_q;
	assign reused     = reused_q;
	assign table_full = full_q;

endmodule

// ===== verif/plane_id_tracker_tb.sv =====
`timescale 1ns / 1ps

module plane_id_tracker_tb;

	localparam pit_pkg::coord_t COORD_MIN = pit_pkg::coord_t'(32'h8000_0000);
	localparam pit_pkg::coord_t COORD_MAX = pit_pkg::coord_t'(32'h7FFF_FFFF);
	localparam logic [pit_pkg::THR_W-1:0] THR_MAX = {pit_pkg::THR_W{1'b1}};
	// divider pass, a full table walk and the emit step, with some margin
	localparam int DRAIN_CYCLES = 3 * (pit_pkg::SUM_W + 2) + 3 * pit_pkg::MAX_PLANES + 16;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct {
		logic [pit_pkg::OUT_ID_W-1:0] id;
		pit_pkg::coord_t              cx;
		pit_pkg::coord_t              cy;
		pit_pkg::coord_t              cz;
		logic                         reused;
		logic                         full;
	} plane_rec_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [pit_pkg::THR_W-1:0]    cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         op = pit_pkg::OP_POINT;
	pit_pkg::coord_t              point_x = '0;
	pit_pkg::coord_t              point_y = '0;
	pit_pkg::coord_t              point_z = '0;
	logic                         last_point = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [pit_pkg::OUT_ID_W-1:0] plane_id;
	pit_pkg::coord_t              centroid_x;
	pit_pkg::coord_t              centroid_y;
	pit_pkg::coord_t              centroid_z;
	logic                         reused;
	logic                         table_full;

	plane_id_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.last_point (last_point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.plane_id   (plane_id),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.centroid_z (centroid_z),
		.reused     (reused),
		.table_full (table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tracker state mirrored on the testbench side
	pit_pkg::coord_t           hist_z [2][pit_pkg::MAX_PLANES];
	pit_pkg::id_t              hist_id [2][pit_pkg::MAX_PLANES];
	logic                      bank_sel = 1'b0;
	int                        prev_cnt = 0;
	int                        cur_cnt = 0;
	pit_pkg::sum_t             acc_x = '0;
	pit_pkg::sum_t             acc_y = '0;
	pit_pkg::sum_t             acc_z = '0;
	pit_pkg::pcnt_t            pt_cnt = '0;
	pit_pkg::id_t              id_next = '0;
	logic [pit_pkg::THR_W-1:0] match_thr = pit_pkg::THR_RESET;

	plane_rec_t planes_due[$];
	int         mismatches = 0;
	int         send_idle = 0;
	int         recv_idle = 0;

	task automatic track_word(input logic o, input pit_pkg::coord_t x,
			input pit_pkg::coord_t y, input pit_pkg::coord_t z, input logic lst);
		plane_rec_t   rec;
		longint       gap;
		longint       best;
		bit           hit;
		pit_pkg::id_t match_id;
		if (o == pit_pkg::OP_EOF) begin
			bank_sel = !bank_sel;
			prev_cnt = cur_cnt;
			cur_cnt  = 0;
			acc_x    = '0;
			acc_y    = '0;
			acc_z    = '0;
			pt_cnt   = '0;
		end else begin
			if (pt_cnt < pit_pkg::MAX_POINTS) begin
				acc_x += x;
				acc_y += y;
				acc_z += z;
				pt_cnt++;
			end
			if (lst) begin
				rec.cx = pit_pkg::coord_t'(acc_x / pit_pkg::sum_t'(pt_cnt));
				rec.cy = pit_pkg::coord_t'(acc_y / pit_pkg::sum_t'(pt_cnt));
				rec.cz = pit_pkg::coord_t'(acc_z / pit_pkg::sum_t'(pt_cnt));
				acc_x  = '0;
				acc_y  = '0;
				acc_z  = '0;
				pt_cnt = '0;
				hit      = 1'b0;
				best     = 0;
				match_id = '0;
				// nearest z in the previous frame, first one wins a tie
				for (int i = 0; i < prev_cnt; i++) begin
					gap = longint'(hist_z[!bank_sel][i]) - longint'(rec.cz);
					if (gap < 0)
						gap = -gap;
					if (gap < longint'(match_thr) && (!hit || gap < best)) begin
						hit      = 1'b1;
						best     = gap;
						match_id = hist_id[!bank_sel][i];
					end
				end
				if (!hit) begin
					match_id = id_next;
					id_next++;
				end
				if (cur_cnt < pit_pkg::MAX_PLANES) begin
					hist_z[bank_sel][cur_cnt]  = rec.cz;
					hist_id[bank_sel][cur_cnt] = match_id;
					cur_cnt++;
					rec.full = 1'b0;
				end else begin
					rec.full = 1'b1;
				end
				rec.id     = match_id[pit_pkg::OUT_ID_W-1:0];
				rec.reused = hit;
				planes_due.insert(planes_due.size(), rec);
			end
		end
	endtask

	task automatic send_word(input logic o, input pit_pkg::coord_t x,
			input pit_pkg::coord_t y, input pit_pkg::coord_t z, input logic lst);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		point_x    <= x;
		point_y    <= y;
		point_z    <= z;
		last_point <= lst;
		do @(posedge clk); while (in_ready !== 1'b1);
		track_word(o, x, y, z, lst);
	endtask

	// the other fields of an end-of-frame word carry junk
	task automatic send_frame_end();
		send_word(pit_pkg::OP_EOF, $urandom, $urandom, $urandom, $urandom_range(0, 1));
	endtask

	task automatic send_plane(input int n, input pit_pkg::coord_t zc, input int z_spread,
			input bit wide);
		pit_pkg::coord_t x;
		pit_pkg::coord_t y;
		pit_pkg::coord_t z;
		for (int k = 0; k < n; k++) begin
			if (wide) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = pit_pkg::coord_t'(int'($urandom_range(0, 2**20)) - 2**19);
				y = pit_pkg::coord_t'(int'($urandom_range(0, 2**20)) - 2**19);
			end
			z = zc + pit_pkg::coord_t'(int'($urandom_range(0, 2 * z_spread)) - z_spread);
			send_word(pit_pkg::OP_POINT, x, y, z, k == n - 1);
		end
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (planes_due.size() != 0);
	endtask

	task automatic program_threshold(input logic [pit_pkg::THR_W-1:0] thr);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data <= thr;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		match_thr = thr;
	endtask

	// empty previous table, extreme coordinates, truncation toward zero
	task automatic test_new_planes();
		send_word(pit_pkg::OP_POINT, COORD_MIN, COORD_MAX, 0, 1'b1);
		send_word(pit_pkg::OP_POINT, COORD_MAX, COORD_MIN, -4, 1'b0);
		send_word(pit_pkg::OP_POINT, COORD_MAX, COORD_MIN, -5, 1'b1);
		send_frame_end();
	endtask

	// previous table holds z 0 and -4
	task automatic test_nearest_match();
		send_word(pit_pkg::OP_POINT, 17, -17, -2, 1'b1);
		// distance equal to the threshold must not match
		send_word(pit_pkg::OP_POINT, -1, 1, pit_pkg::coord_t'(int'(pit_pkg::THR_RESET)), 1'b1);
		send_word(pit_pkg::OP_POINT, 0, 0, COORD_MAX, 1'b1);
		send_frame_end();
	endtask

	task automatic test_threshold_extremes();
		program_threshold(THR_MAX);
		send_word(pit_pkg::OP_POINT, 5, 5, COORD_MIN, 1'b1);
		program_threshold('0);
		send_word(pit_pkg::OP_POINT, -5, -5, -2, 1'b1);
		program_threshold(pit_pkg::THR_RESET);
	endtask

	task automatic test_frame_abort();
		send_word(pit_pkg::OP_POINT, $urandom, $urandom, $urandom, 1'b0);
		send_word(pit_pkg::OP_POINT, $urandom, $urandom, $urandom, 1'b0);
		send_frame_end();
		send_word(pit_pkg::OP_POINT, 1000, -1000, 123456, 1'b1);
		send_frame_end();
	endtask

	// points past the accumulator capacity must not count, the last one too
	task automatic test_point_overflow();
		for (int k = 0; k < pit_pkg::MAX_POINTS + 4; k++) begin
			if (k < pit_pkg::MAX_POINTS)
				send_word(pit_pkg::OP_POINT, COORD_MIN, COORD_MAX, $urandom, 1'b0);
			else
				send_word(pit_pkg::OP_POINT, COORD_MAX, COORD_MIN, $urandom,
					k == pit_pkg::MAX_POINTS + 3);
		end
		send_plane(1, 42, 0, 1'b1);
		send_frame_end();
	endtask

	task automatic test_table_full();
		send_frame_end();
		send_frame_end();
		for (int k = 0; k < pit_pkg::MAX_PLANES + 2; k++)
			send_plane(1, pit_pkg::coord_t'(k * 100000), 0, 1'b0);
		send_frame_end();
		send_plane(1, pit_pkg::coord_t'((pit_pkg::MAX_PLANES - 1) * 100000 + 3), 0, 1'b0);
		send_plane(1, pit_pkg::coord_t'(pit_pkg::MAX_PLANES * 100000), 0, 1'b0);
		send_plane(2, 0, 100, 1'b1);
		send_frame_end();
	endtask

	// frames of planes around a drifting set of z levels, with some noise mixed in
	task automatic test_random_frames(input int s_idle, input int r_idle,
			input logic [pit_pkg::THR_W-1:0] thr, input int n_words);
		pit_pkg::coord_t levels [8];
		pit_pkg::coord_t zc;
		int              sent;
		int              jit_span;
		int              n_pts;
		program_threshold(thr);
		send_idle = s_idle;
		recv_idle = r_idle;
		jit_span  = (thr > 20000) ? 20000 : int'(thr) + 64;
		for (int i = 0; i < 8; i++)
			levels[i] = pit_pkg::coord_t'(int'($urandom_range(0, 2**22)) - 2**21);
		sent = 0;
		while (sent < n_words) begin
			for (int p = $urandom_range(1, 10); p > 0; p--) begin
				if ($urandom_range(0, 19) == 0) begin
					// plane cut short by the end of the frame
					n_pts = $urandom_range(1, 3);
					for (int k = 0; k < n_pts; k++)
						send_word(pit_pkg::OP_POINT, $urandom, $urandom, $urandom, 1'b0);
					sent += n_pts;
					break;
				end
				if ($urandom_range(0, 4) == 0)
					zc = $urandom;
				else
					zc = levels[$urandom_range(0, 7)]
						+ pit_pkg::coord_t'(int'($urandom_range(0, 2 * jit_span)) - jit_span);
				n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
					: $urandom_range(1, 4);
				send_plane(n_pts, zc, $urandom_range(0, 300), $urandom_range(0, 3) == 0);
				sent += n_pts;
				if (sent < 12 || $urandom_range(0, 24) == 0)
					wait_results();
			end
			send_frame_end();
			sent++;
			if ($urandom_range(0, 3) == 0)
				levels[$urandom_range(0, 7)] =
					pit_pkg::coord_t'(int'($urandom_range(0, 2**22)) - 2**21);
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle);

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		plane_rec_t due;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (planes_due.size() == 0) begin
				$error("plane result with no plane pending, id %0h", plane_id);
				mismatches++;
			end else begin
				due = planes_due.pop_front();
				check_field("plane_id", due.id, plane_id);
				check_field("centroid_x", due.cx, centroid_x);
				check_field("centroid_y", due.cy, centroid_y);
				check_field("centroid_z", due.cz, centroid_z);
				check_field("reused", due.reused, reused);
				check_field("table_full", due.full, table_full);
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout with %0d planes pending", planes_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 20;
		recv_idle = 76;
		test_new_planes();
		test_nearest_match();
		test_threshold_extremes();
		test_frame_abort();
		test_point_overflow();
		test_table_full();
		test_random_frames(20, 76, $urandom_range(1000, 20000), 50);
		test_random_frames(76, 20, $urandom_range(0, 400), 50);
		test_random_frames(0, 0, pit_pkg::THR_RESET, 50);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && planes_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
